>>> sv/hslp_pkg.sv
package hslp_pkg;

    // Default number of byte slots in one collected line.
    localparam int LINE_BYTES_DEF = 64;

    localparam int KIND_W      = 2;
    localparam int PERCENT_W   = 7;
    localparam int TOKENS_W    = 32;
    localparam int STATUS_W    = 48;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_PONG = 2'd0;
    localparam kind_t KIND_OK   = 2'd1;
    localparam kind_t KIND_ERR  = 2'd2;

    localparam logic [TOKENS_W-1:0] PERCENT_MAX = 32'd100;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Number of header bytes that open a status line.
    localparam int LEAD_LEN = 6;
    // Number of bytes of the identity request.
    localparam int PING_LEN = 4;

    // Bytes of the identity request, "PING".
    function automatic logic [7:0] ping_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h50;
            2'd1:    c = 8'h49;
            2'd2:    c = 8'h4E;
            default: c = 8'h47;
        endcase
        return c;
    endfunction

    // Bytes of the status line header: five capital letters and a space.
    function automatic logic [7:0] lead_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h43;
            3'd1:    c = 8'h4F;
            3'd2:    c = 8'h44;
            3'd3:    c = 8'h45;
            3'd4:    c = 8'h58;
            3'd5:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Whitespace as the C library classifies it.
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B)
            || (c == 8'h0C) || (c == 8'h0D);
    endfunction

    // Final value of a parsed number: saturated on overflow, else negated
    // modulo 2^32 when a minus sign was seen.
    function automatic logic [TOKENS_W-1:0] number_value(
        input logic [TOKENS_W-1:0] acc,
        input logic                neg,
        input logic                over
    );
        logic [TOKENS_W-1:0] v;
        if (over)
            v = '1;
        else if (neg)
            v = TOKENS_W'(0) - acc;
        else
            v = acc;
        return v;
    endfunction

endpackage

>>> sv/host_status_line_parser.sv
// Host status line parser.
//
// The slave stream takes one byte of the host text link per item. Carriage
// returns are dropped, every other byte except newline is parsed on the fly
// as it arrives, and a newline closes the line and yields exactly one reply
// item on the master stream. The reply carries its kind in m_tuser (pong,
// OK or ERR) and the kept status, as it stands after the line, in m_tdata.
//
// Throughput is one byte per cycle while the input is ready: each byte
// passes through a single parse step (compare, classify and one
// multiply-by-ten add) into the parse registers. A reply is registered
// in the output register in the cycle after its newline is accepted. The
// input stays ready while the output register is empty or being drained,
// so while a reply waits there untaken, the sender stalls for every byte.
//
// Reset clears the parse state, the kept status (all zero, no status
// available) and the output valid flag. There is no clearing pass.

module host_status_line_parser #(
    parameter int LINE_BYTES = hslp_pkg::LINE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [6:0] left_percent, [38:7] total_tokens,
                                   // [45:39] week_left_percent,
                                   // [46] week_present, [47] status_available
    output logic [1:0]  m_tuser    // [1:0] reply_kind
);
    import hslp_pkg::*;

    localparam int CNT_W = $clog2(LINE_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_BYTES - 1);

    // Parse phases.
    localparam logic [3:0] PH_HEAD     = 4'd0;   // matching the header bytes
    localparam logic [3:0] PH_L_BLANK  = 4'd1;   // left percent, before sign
    localparam logic [3:0] PH_L_SIGNED = 4'd2;   // left percent, sign seen
    localparam logic [3:0] PH_L_DIG    = 4'd3;   // left percent digits
    localparam logic [3:0] PH_T_START  = 4'd4;   // token field, nothing yet
    localparam logic [3:0] PH_T_SP     = 4'd5;   // token field is one space
    localparam logic [3:0] PH_T_BLANK  = 4'd6;   // token field, other blanks
    localparam logic [3:0] PH_T_SIGNED = 4'd7;   // token field, sign seen
    localparam logic [3:0] PH_T_DIG    = 4'd8;   // token digits
    localparam logic [3:0] PH_W_START  = 4'd9;   // weekly field, nothing yet
    localparam logic [3:0] PH_W_BLANK  = 4'd10;  // weekly field, blanks
    localparam logic [3:0] PH_W_SIGNED = 4'd11;  // weekly field, sign seen
    localparam logic [3:0] PH_W_DIG    = 4'd12;  // weekly digits
    localparam logic [3:0] PH_BAD      = 4'd13;  // line can only give ERR

    // Line and parse state.
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [3:0]           phase_reg, phase_next;
    logic [2:0]           head_pos_reg, head_pos_next;
    logic                 head_ping_reg, head_ping_next;
    logic                 head_lead_reg, head_lead_next;
    logic [TOKENS_W-1:0]  acc_reg, acc_next;
    logic                 neg_reg, neg_next;
    logic                 over_reg, over_next;
    logic                 ended_reg, ended_next;
    logic [PERCENT_W-1:0] pend_left_reg, pend_left_next;
    logic [TOKENS_W-1:0]  pend_tokens_reg, pend_tokens_next;

    // Kept status.
    logic [PERCENT_W-1:0] kept_left_reg, kept_left_next;
    logic [TOKENS_W-1:0]  kept_tokens_reg, kept_tokens_next;
    logic [PERCENT_W-1:0] kept_week_reg, kept_week_next;
    logic                 kept_week_av_reg, kept_week_av_next;
    logic                 kept_av_reg, kept_av_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    kind_t                out_kind_reg, out_kind_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;

    // Byte classification and arithmetic of the current item.
    logic                 take;
    logic [7:0]           rx;
    logic                 rx_digit;
    logic                 rx_sign;
    logic                 rx_blank;
    logic [3:0]           digit_val;
    logic [TOKENS_W+3:0]  acc_step;
    logic [TOKENS_W-1:0]  num_val;
    logic                 num_pct_ok;
    logic                 head_ping_hit;
    logic                 head_lead_hit;
    kind_t                verdict;
    logic                 upd_status;
    logic [TOKENS_W-1:0]  upd_tokens;
    logic [PERCENT_W-1:0] upd_week;
    logic                 upd_week_av;

    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;
    assign rx       = s_tdata;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_status_reg;
    assign m_tuser  = out_kind_reg;

    assign rx_digit  = (rx >= CHAR_ZERO) && (rx <= CHAR_NINE);
    assign rx_sign   = (rx == CHAR_PLUS) || (rx == CHAR_MINUS);
    assign rx_blank  = is_blank(rx);
    assign digit_val = 4'(rx - CHAR_ZERO);

    // One decimal step: acc * 10 + digit, kept wide enough to see overflow.
    assign acc_step = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {(TOKENS_W)'(0), digit_val};

    assign num_val    = number_value(acc_reg, neg_reg, over_reg);
    assign num_pct_ok = num_val <= PERCENT_MAX;

    assign head_ping_hit = head_ping_reg && (head_pos_reg < 3'(PING_LEN))
                        && (rx == ping_char(head_pos_reg[1:0]));
    assign head_lead_hit = head_lead_reg && (rx == lead_char(head_pos_reg));

    // Verdict for a line that ends in the current phase.
    always_comb
    begin
        verdict     = KIND_ERR;
        upd_status  = 1'b0;
        upd_tokens  = '0;
        upd_week    = '0;
        upd_week_av = 1'b0;
        case (phase_reg)
            PH_HEAD:
            begin
                if (head_ping_reg && (head_pos_reg == 3'(PING_LEN)))
                    verdict = KIND_PONG;
            end
            PH_T_START:
            begin
                verdict    = KIND_OK;
                upd_status = 1'b1;
            end
            PH_T_SP:
            begin
                // A lone space reads as an empty token count and an empty
                // weekly percent.
                verdict     = KIND_OK;
                upd_status  = 1'b1;
                upd_week_av = 1'b1;
            end
            PH_T_DIG:
            begin
                verdict    = KIND_OK;
                upd_status = 1'b1;
                upd_tokens = num_val;
            end
            PH_W_START:
            begin
                verdict     = KIND_OK;
                upd_status  = 1'b1;
                upd_tokens  = pend_tokens_reg;
                upd_week_av = 1'b1;
            end
            PH_W_DIG:
            begin
                if (num_pct_ok)
                begin
                    verdict     = KIND_OK;
                    upd_status  = 1'b1;
                    upd_tokens  = pend_tokens_reg;
                    upd_week    = num_val[PERCENT_W-1:0];
                    upd_week_av = 1'b1;
                end
            end
            default:
            begin
                verdict = KIND_ERR;
            end
        endcase
    end

    always_comb
    begin
        count_next        = count_reg;
        phase_next        = phase_reg;
        head_pos_next     = head_pos_reg;
        head_ping_next    = head_ping_reg;
        head_lead_next    = head_lead_reg;
        acc_next          = acc_reg;
        neg_next          = neg_reg;
        over_next         = over_reg;
        ended_next        = ended_reg;
        pend_left_next    = pend_left_reg;
        pend_tokens_next  = pend_tokens_reg;
        kept_left_next    = kept_left_reg;
        kept_tokens_next  = kept_tokens_reg;
        kept_week_next    = kept_week_reg;
        kept_week_av_next = kept_week_av_reg;
        kept_av_next      = kept_av_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_kind_next     = out_kind_reg;
        out_status_next   = out_status_reg;

        if (take && (rx != CHAR_CR))
        begin
            if ((rx == CHAR_LF) || (count_reg == CNT_LAST))
            begin
                // Newline closes the line; a byte that would fill the line
                // buffer is dropped and collection starts over.
                count_next     = '0;
                phase_next     = PH_HEAD;
                head_pos_next  = '0;
                head_ping_next = 1'b1;
                head_lead_next = 1'b1;
                acc_next       = '0;
                neg_next       = 1'b0;
                over_next      = 1'b0;
                ended_next     = 1'b0;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end

            if (rx == CHAR_LF)
            begin
                if (upd_status)
                begin
                    kept_left_next    = pend_left_reg;
                    kept_tokens_next  = upd_tokens;
                    kept_week_next    = upd_week;
                    kept_week_av_next = upd_week_av;
                    kept_av_next      = 1'b1;
                end
                out_valid_next  = 1'b1;
                out_kind_next   = verdict;
                if (upd_status)
                    out_status_next = {1'b1, upd_week_av, upd_week, upd_tokens,
                                       pend_left_reg};
                else
                    out_status_next = {kept_av_reg, kept_week_av_reg, kept_week_reg,
                                       kept_tokens_reg, kept_left_reg};
            end
            else if ((count_reg != CNT_LAST) && !ended_reg)
            begin
                if (rx == CHAR_NUL)
                begin
                    // The text ends here; later bytes only count length.
                    ended_next = 1'b1;
                end
                else
                begin
                    case (phase_reg)
                        PH_HEAD:
                        begin
                            if (head_pos_reg == 3'(LEAD_LEN - 1))
                                phase_next = head_lead_hit ? PH_L_BLANK : PH_BAD;
                            else if (!head_ping_hit && !head_lead_hit)
                                phase_next = PH_BAD;
                            head_pos_next  = head_pos_reg + 1'b1;
                            head_ping_next = head_ping_hit;
                            head_lead_next = head_lead_hit;
                        end
                        PH_L_BLANK, PH_T_START, PH_T_SP, PH_T_BLANK,
                        PH_W_START, PH_W_BLANK:
                        begin
                            if (rx_digit)
                            begin
                                acc_next = TOKENS_W'(digit_val);
                                case (phase_reg)
                                    PH_L_BLANK: phase_next = PH_L_DIG;
                                    PH_W_START,
                                    PH_W_BLANK: phase_next = PH_W_DIG;
                                    default:    phase_next = PH_T_DIG;
                                endcase
                            end
                            else if (rx_sign)
                            begin
                                neg_next = (rx == CHAR_MINUS);
                                case (phase_reg)
                                    PH_L_BLANK: phase_next = PH_L_SIGNED;
                                    PH_W_START,
                                    PH_W_BLANK: phase_next = PH_W_SIGNED;
                                    default:    phase_next = PH_T_SIGNED;
                                endcase
                            end
                            else if (rx_blank)
                            begin
                                case (phase_reg)
                                    PH_L_BLANK: phase_next = PH_L_BLANK;
                                    PH_T_START: phase_next = (rx == CHAR_SPACE)
                                                             ? PH_T_SP : PH_T_BLANK;
                                    PH_W_START,
                                    PH_W_BLANK: phase_next = PH_W_BLANK;
                                    default:    phase_next = PH_T_BLANK;
                                endcase
                            end
                            else
                            begin
                                phase_next = PH_BAD;
                            end
                        end
                        PH_L_SIGNED, PH_T_SIGNED, PH_W_SIGNED:
                        begin
                            if (rx_digit)
                            begin
                                acc_next = TOKENS_W'(digit_val);
                                case (phase_reg)
                                    PH_L_SIGNED: phase_next = PH_L_DIG;
                                    PH_T_SIGNED: phase_next = PH_T_DIG;
                                    default:     phase_next = PH_W_DIG;
                                endcase
                            end
                            else
                            begin
                                phase_next = PH_BAD;
                            end
                        end
                        PH_L_DIG, PH_T_DIG, PH_W_DIG:
                        begin
                            if (rx_digit)
                            begin
                                // Once saturated the magnitude stays there.
                                if (!over_reg)
                                begin
                                    acc_next  = acc_step[TOKENS_W-1:0];
                                    over_next = |acc_step[TOKENS_W+3:TOKENS_W];
                                end
                            end
                            else if ((rx == CHAR_SPACE) && (phase_reg == PH_L_DIG))
                            begin
                                if (num_pct_ok)
                                begin
                                    pend_left_next = num_val[PERCENT_W-1:0];
                                    phase_next     = PH_T_START;
                                end
                                else
                                begin
                                    phase_next = PH_BAD;
                                end
                                acc_next  = '0;
                                neg_next  = 1'b0;
                                over_next = 1'b0;
                            end
                            else if ((rx == CHAR_SPACE) && (phase_reg == PH_T_DIG))
                            begin
                                pend_tokens_next = num_val;
                                phase_next       = PH_W_START;
                                acc_next         = '0;
                                neg_next         = 1'b0;
                                over_next        = 1'b0;
                            end
                            else
                            begin
                                phase_next = PH_BAD;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_BAD;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            phase_reg        <= PH_HEAD;
            head_pos_reg     <= '0;
            head_ping_reg    <= 1'b1;
            head_lead_reg    <= 1'b1;
            acc_reg          <= '0;
            neg_reg          <= 1'b0;
            over_reg         <= 1'b0;
            ended_reg        <= 1'b0;
            pend_left_reg    <= '0;
            pend_tokens_reg  <= '0;
            kept_left_reg    <= '0;
            kept_tokens_reg  <= '0;
            kept_week_reg    <= '0;
            kept_week_av_reg <= 1'b0;
            kept_av_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            phase_reg        <= phase_next;
            head_pos_reg     <= head_pos_next;
            head_ping_reg    <= head_ping_next;
            head_lead_reg    <= head_lead_next;
            acc_reg          <= acc_next;
            neg_reg          <= neg_next;
            over_reg         <= over_next;
            ended_reg        <= ended_next;
            pend_left_reg    <= pend_left_next;
            pend_tokens_reg  <= pend_tokens_next;
            kept_left_reg    <= kept_left_next;
            kept_tokens_reg  <= kept_tokens_next;
            kept_week_reg    <= kept_week_next;
            kept_week_av_reg <= kept_week_av_next;
            kept_av_reg      <= kept_av_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Reply payload needs no reset; it is qualified by m_tvalid.
    always_ff @(posedge clk)
    begin
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
    end

endmodule

>>> tb/sv/hslp_reply_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the status line parser, keeps its own copy of the
// line buffer and the kept status, and compares every reply with the oldest
// predicted one.
module hslp_reply_checker #(
    parameter int LINE_BYTES = hslp_pkg::LINE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // [6:0] left_percent, [38:7] total_tokens,
                                   // [45:39] week_left_percent,
                                   // [46] week_present, [47] status_available
    input  logic [1:0]  m_tuser,   // [1:0] reply_kind
    input  logic        wrap_up,
    output int          replies_owed,
    output int          fail_count
);
    import hslp_pkg::*;

    // The identity request with its terminating zero, and the status header.
    localparam logic [39:0] PING_WORD = 40'h00_47_4E_49_50;
    localparam logic [47:0] LEAD_WORD = 48'h20_58_45_44_4F_43;

    typedef struct packed {
        kind_t       kind;
        logic [6:0]  left;
        logic [31:0] tokens;
        logic [6:0]  week;
        logic        week_ok;
        logic        status_ok;
    } reply_t;

    reply_t      owed_q[$];
    logic [7:0]  line_buf[LINE_BYTES];
    int unsigned fill;
    logic [6:0]  kept_left;
    logic [31:0] kept_tokens;
    logic [6:0]  kept_week;
    logic        kept_week_ok;
    logic        kept_status_ok;
    logic        wrapped = 1'b0;
    int          bytes_seen = 0;
    int          pong_seen = 0;
    int          ok_seen = 0;
    int          err_seen = 0;

    initial fail_count = 0;
    initial replies_owed = 0;

    task automatic flag_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        fail_count++;
    endtask

    function automatic logic [7:0] char_at(input int unsigned pos);
        logic [7:0] c;
        c = (pos >= LINE_BYTES) ? CHAR_NUL : line_buf[pos];
        return c;
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B)
            || (c == 8'h0C) || (c == 8'h0D);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Decimal field with the usual library conversion rules. When no digit
    // follows the blanks and sign, nothing is consumed and the value is 0.
    function automatic logic [31:0] scan_number(input int unsigned pos,
                                                output int unsigned stop);
        int unsigned p;
        logic        neg;
        logic        over;
        logic [63:0] acc;
        logic [31:0] value;
        p = pos;
        neg = 1'b0;
        over = 1'b0;
        acc = '0;
        while (p < LINE_BYTES && blank_char(char_at(p)))
            p++;
        if (char_at(p) == CHAR_PLUS || char_at(p) == CHAR_MINUS) begin
            neg = (char_at(p) == CHAR_MINUS);
            p++;
        end
        if (!digit_char(char_at(p))) begin
            stop = pos;
            return '0;
        end
        while (p < LINE_BYTES && digit_char(char_at(p))) begin
            if (!over) begin
                acc = acc * 10 + 64'(char_at(p) - CHAR_ZERO);
                if (acc > 64'hFFFF_FFFF)
                    over = 1'b1;
            end
            p++;
        end
        stop = p;
        if (over)
            value = '1;
        else if (neg)
            value = 32'd0 - acc[31:0];
        else
            value = acc[31:0];
        return value;
    endfunction

    // Classifies the collected line and, for a good status line, updates the
    // kept status.
    function automatic kind_t judge_line();
        int unsigned stop;
        logic [31:0] left;
        logic [31:0] tokens;
        logic [31:0] week;
        logic        week_ok;
        logic        match;
        match = 1'b1;
        for (int i = 0; i < 5; i++)
            if (line_buf[i] != PING_WORD[8*i +: 8])
                match = 1'b0;
        if (match)
            return KIND_PONG;
        for (int i = 0; i < 6; i++)
            if (line_buf[i] != LEAD_WORD[8*i +: 8])
                return KIND_ERR;
        week = '0;
        week_ok = 1'b0;
        left = scan_number(6, stop);
        if (stop == 6 || char_at(stop) != CHAR_SPACE || left > PERCENT_MAX)
            return KIND_ERR;
        tokens = scan_number(stop + 1, stop);
        if (char_at(stop) == CHAR_SPACE) begin
            week = scan_number(stop + 1, stop);
            if (week > PERCENT_MAX)
                return KIND_ERR;
            week_ok = 1'b1;
        end
        if (char_at(stop) != CHAR_NUL)
            return KIND_ERR;
        kept_left = left[6:0];
        kept_tokens = tokens;
        kept_week = week[6:0];
        kept_week_ok = week_ok;
        kept_status_ok = 1'b1;
        return KIND_OK;
    endfunction

    task automatic take_byte(input logic [7:0] b);
        reply_t r;
        bytes_seen++;
        if (b == CHAR_CR)
            return;
        if (b != CHAR_LF) begin
            if (fill + 1 < LINE_BYTES) begin
                line_buf[fill] = b;
                fill++;
            end
            else begin
                fill = 0;
            end
            return;
        end
        if (fill >= LINE_BYTES)
            fill = 0;
        line_buf[fill] = CHAR_NUL;
        r.kind = judge_line();
        fill = 0;
        r.left = kept_left;
        r.tokens = kept_tokens;
        r.week = kept_week;
        r.week_ok = kept_week_ok;
        r.status_ok = kept_status_ok;
        owed_q.push_back(r);
    endtask

    task automatic check_reply();
        reply_t r;
        if (owed_q.size() == 0) begin
            flag_mismatch($sformatf("reply kind %0d arrived with none owed", m_tuser));
            return;
        end
        r = owed_q.pop_front();
        case (r.kind)
            KIND_PONG: pong_seen++;
            KIND_OK:   ok_seen++;
            default:   err_seen++;
        endcase
        if (m_tuser !== r.kind)
            flag_mismatch($sformatf("reply_kind %0d, predicted %0d", m_tuser, r.kind));
        if (m_tdata[6:0] !== r.left)
            flag_mismatch($sformatf("left_percent %0d, predicted %0d",
                                    m_tdata[6:0], r.left));
        if (m_tdata[38:7] !== r.tokens)
            flag_mismatch($sformatf("total_tokens %0d, predicted %0d",
                                    m_tdata[38:7], r.tokens));
        if (m_tdata[45:39] !== r.week)
            flag_mismatch($sformatf("week_left_percent %0d, predicted %0d",
                                    m_tdata[45:39], r.week));
        if (m_tdata[46] !== r.week_ok)
            flag_mismatch($sformatf("week_present %b, predicted %b",
                                    m_tdata[46], r.week_ok));
        if (m_tdata[47] !== r.status_ok)
            flag_mismatch($sformatf("status_available %b, predicted %b",
                                    m_tdata[47], r.status_ok));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_q.delete();
            for (int i = 0; i < LINE_BYTES; i++)
                line_buf[i] = CHAR_NUL;
            fill = 0;
            kept_left = '0;
            kept_tokens = '0;
            kept_week = '0;
            kept_week_ok = 1'b0;
            kept_status_ok = 1'b0;
            replies_owed <= 0;
        end
        else
        begin
            // A reply leaving now belongs to an earlier newline, so the
            // output side is handled before the byte taken at this edge.
            if (m_tvalid && m_tready)
                check_reply();
            if (s_tvalid && s_tready)
                take_byte(s_tdata);
            if (wrap_up && !wrapped)
            begin
                wrapped = 1'b1;
                if (owed_q.size() != 0)
                    flag_mismatch($sformatf("%0d replies never arrived", owed_q.size()));
                $display("Summary: %0d bytes taken, %0d replies checked (pong %0d, OK %0d, ERR %0d).",
                         bytes_seen, pong_seen + ok_seen + err_seen,
                         pong_seen, ok_seen, err_seen);
                $display("Summary: directed edge lines, a long output hold-off and four idling mixes.");
            end
            replies_owed <= owed_q.size();
        end
    end

endmodule

>>> tb/sv/tb_host_status_line_parser.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the host status line parser. Lines of bytes are
// assembled in a queue and then fed to the slave stream one byte per item;
// the checker beside the block predicts and compares every reply.
module tb_host_status_line_parser;
    import hslp_pkg::*;

    // How long the receiver refuses replies during the back-pressure test.
    localparam int HOLD_CYCLES = 400;
    // Cycles allowed for the last replies to drain at the end of the run.
    localparam int DRAIN_LIMIT = 2000;
    // Each random phase runs until both of these are reached.
    localparam int PHASE_BYTES = 100;
    localparam int PHASE_LINES = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // [6:0] left_percent, [38:7] total_tokens,
                                 // [45:39] week_left_percent,
                                 // [46] week_present, [47] status_available
    logic [1:0]  m_tuser;        // [1:0] reply_kind
    logic        wrap_up = 1'b0;
    int          replies_owed;
    int          fail_count;

    // Idling mix of the current phase, in percent of cycles.
    int          sender_idle_pct = 0;
    int          recv_stall_pct = 0;

    // A toggle of hold_go asks the receiver process for one long hold-off.
    logic        hold_go = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_cnt = 0;

    // Bytes of the line being assembled, newline not included.
    logic [7:0]  line_bytes[$];
    int          phase_bytes;
    int          phase_lines;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    host_status_line_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    hslp_reply_checker reply_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .wrap_up      (wrap_up),
        .replies_owed (replies_owed),
        .fail_count   (fail_count)
    );

    // Receiver side. A pending hold request takes priority and keeps tready
    // low while hold_cnt counts down; otherwise tready follows the stall mix.
    always @(posedge clk)
    begin
        if (hold_go != hold_seen)
        begin
            hold_seen = hold_go;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one byte, after a random number of idle cycles, and returns at
    // the edge where it is taken. tvalid stays high on return so that
    // back-to-back bytes need no gap; anything that waits must lower it.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do
            @(posedge clk);
        while (!s_tready);
        phase_bytes++;
    endtask

    // Sends the assembled line and its newline. Carriage returns are sprinkled
    // in now and then, since the block must drop them wherever they fall.
    task automatic send_line();
        foreach (line_bytes[i])
        begin
            if ($urandom_range(29) == 0)
                send_byte(CHAR_CR);
            send_byte(line_bytes[i]);
        end
        if ($urandom_range(3) == 0)
            send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        line_bytes.delete();
        phase_lines++;
    endtask

    // Holds the sender off until every predicted reply has been seen.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_owed != 0)
            @(posedge clk);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endtask

    task automatic put_repeat(input logic [7:0] c, input int n);
        for (int i = 0; i < n; i++)
            line_bytes.push_back(c);
    endtask

    // The six-byte header that opens every status line.
    task automatic put_lead();
        for (int i = 0; i < LEAD_LEN; i++)
            line_bytes.push_back(lead_char(3'(i)));
    endtask

    // Mostly nothing; sometimes blanks that the number parser must skip.
    function automatic string blank_run();
        int    pick;
        string s;
        pick = $urandom_range(9);
        if (pick < 7)
            s = "";
        else if (pick == 7)
            s = " ";
        else if (pick == 8)
            s = "\t ";
        else
            s = "\v\f";
        return s;
    endfunction

    function automatic string digit_run(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = $sformatf("%s%0d", s, $urandom_range(9));
        return s;
    endfunction

    // A percent field: mostly in range, with the limits, values just over,
    // signs, leading zeros and the empty field mixed in.
    function automatic string pct_text();
        string s;
        case ($urandom_range(19))
            0:       s = "0";
            1:       s = "100";
            2:       s = $sformatf("%0d", $urandom_range(255, 101));
            3:       s = $sformatf("-%0d", $urandom_range(100));
            4:       s = $sformatf("+%0d", $urandom_range(100));
            5:       s = $sformatf("00%0d", $urandom_range(100));
            6:       s = "";
            default: s = $sformatf("%0d", $urandom_range(100));
        endcase
        return {blank_run(), s};
    endfunction

    // A token field: full 32-bit range, the saturation edge, long digit runs,
    // negative values and the empty field.
    function automatic string count_text();
        string s;
        case ($urandom_range(15))
            0:       s = "0";
            1:       s = "4294967295";
            2:       s = "4294967296";
            3:       s = digit_run($urandom_range(20, 11));
            4:       s = $sformatf("-%0d", $urandom);
            5:       s = "";
            6:       s = $sformatf("-%s", digit_run($urandom_range(20, 11)));
            7, 8:    s = $sformatf("%0d", $urandom_range(999));
            default: s = $sformatf("%0d", $urandom);
        endcase
        return {blank_run(), s};
    endfunction

    task automatic build_status_line();
        put_lead();
        put_text(pct_text());
        put_text(" ");
        put_text(count_text());
        if ($urandom_range(1))
        begin
            put_text(" ");
            put_text(pct_text());
        end
    endtask

    task automatic build_ping_line();
        case ($urandom_range(9))
            7:
            begin
                // The text ends at the zero byte; what follows is ignored.
                put_text("PING");
                line_bytes.push_back(CHAR_NUL);
                put_repeat(8'($urandom), $urandom_range(3));
            end
            8:       put_text("PIN");
            9:       put_text({"PING", blank_run(), "x"});
            default: put_text("PING");
        endcase
    endtask

    // Status lines that go wrong somewhere: cut-off header, missing
    // separator, trailing junk, or no left percent at all.
    task automatic build_broken_line();
        int cut;
        case ($urandom_range(4))
            0:
            begin
                cut = $urandom_range(LEAD_LEN - 1);
                for (int i = 0; i < cut; i++)
                    line_bytes.push_back(lead_char(3'(i)));
                put_text(pct_text());
            end
            1:
            begin
                put_lead();
                put_text({pct_text(), ",", count_text()});
            end
            2:
            begin
                put_lead();
                put_text({pct_text(), " ", count_text(), " ", pct_text(), " ",
                          digit_run($urandom_range(3, 1))});
            end
            3:
            begin
                put_lead();
                put_text({pct_text(), " ", count_text(), "x"});
            end
            default:
            begin
                put_lead();
                put_text({"abc ", count_text()});
            end
        endcase
    endtask

    // Raw bytes over the whole range; a newline among them simply ends the
    // line early and the checker predicts the extra reply.
    task automatic build_noise_line();
        int n;
        n = $urandom_range(20);
        for (int i = 0; i < n; i++)
            line_bytes.push_back(8'($urandom_range(255)));
    endtask

    // Lines around the length limit, so that collection restarts sometimes.
    task automatic build_long_line();
        int n;
        n = $urandom_range(90, 55);
        for (int i = 0; i < n; i++)
            line_bytes.push_back(8'($urandom_range(126, 32)));
        if ($urandom_range(1))
            put_text("PING");
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int pick;
        sender_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        phase_bytes = 0;
        phase_lines = 0;
        while (phase_bytes < PHASE_BYTES || phase_lines < PHASE_LINES)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                build_status_line();
            else if (pick < 65)
                build_ping_line();
            else if (pick < 75)
                build_broken_line();
            else if (pick < 85)
                build_noise_line();
            else if (pick < 90)
                build_long_line();
            else if (pick < 95)
                line_bytes.delete();
            else
            begin
                // A good status line whose text is cut short by a zero byte.
                build_status_line();
                line_bytes.push_back(CHAR_NUL);
                put_text("junk");
            end
            send_line();
        end
        pause_until_drained();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines: exact identity request, empty line, status lines at
        // the field limits, many ways a status line can be rejected, blanks
        // and signs in the numbers, saturation, the zero byte and the length
        // limit.
        put_text("PING");                     send_line();
        send_line();
        put_lead(); put_text("50 1234");      send_line();
        put_lead(); put_text("100 4294967295 100"); send_line();
        put_lead(); put_text("0 0 0");        send_line();
        put_lead(); put_text("101 5");        send_line();
        put_lead(); put_text(" \t+7 -1 3");   send_line();
        put_lead(); put_text("5 99999999999 7"); send_line();
        put_lead(); put_text("5 -99999999999"); send_line();
        put_lead(); put_text("5 ");           send_line();
        put_lead(); put_text("5 x");          send_line();
        put_lead(); put_text("x 5");          send_line();
        put_lead(); put_text("5");            send_line();
        put_lead(); put_text("-1 5");         send_line();
        put_lead(); put_text("-0 5");         send_line();
        put_lead(); put_text("5 6 101");      send_line();
        put_lead(); put_text("5 6 -3");       send_line();
        put_lead(); put_text("5 6 ");         send_line();
        put_lead(); put_text("5 6 7 8");      send_line();
        put_lead(); put_text("\v\f12 +8 +9"); send_line();
        put_text("PING");
        line_bytes.push_back(CHAR_NUL);
        put_text("Z");                        send_line();
        put_text("PINGS");                    send_line();
        put_text("ping");                     send_line();
        // Longest line that still fits: header, "5 " and 55 digits.
        put_lead(); put_text("5 "); put_repeat(CHAR_ZERO, 54); put_text("9");
        send_line();
        // The 64th byte is dropped and collection starts over.
        put_repeat(8'h41, 63); put_text("XPING"); send_line();
        pause_until_drained();

        // Back-pressure: the receiver holds off while identity requests keep
        // coming, so the output register fills and the input must stall.
        hold_go <= ~hold_go;
        for (int i = 0; i < 6; i++)
        begin
            put_text("PING");
            send_line();
        end
        pause_until_drained();

        run_phase(0, 0);
        run_phase(70, 0);
        run_phase(0, 70);
        run_phase(26, 26);

        s_tvalid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && replies_owed != 0; i++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);

        if (fail_count == 0)
            $display("host_status_line_parser test passed");
        else
            $display("host_status_line_parser test failed");
        $finish;
    end

    // Safety net far beyond the slowest legal run.
    initial
    begin
        #1_600_000;
        $display("host_status_line_parser test failed");
        $finish;
    end

endmodule
